### rtl/scd_pkg.sv
// Shared types and constants of the stale connection detector.
package scd_pkg;

   // Field widths
   localparam int ID_W        = 32;
   localparam int STATE_W     = 4;
   localparam int COUNT_W     = 16;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 40;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   // Register reset values and counter ceiling
   localparam logic [COUNT_W-1:0] THRESH_RESET = 16'd1200;
   localparam logic [STATE_W-1:0] WATCH_RESET  = 4'd8;
   localparam logic [COUNT_W-1:0] COUNT_MAX    = 16'hFFFF;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_DWELL_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WATCH_STATE     = 2'd1;

   // One tracked connection as stored in the table
   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [STATE_W-1:0] state;
      logic [COUNT_W-1:0] count;
      logic               marked;
   } entry_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT
   } ctrl_state_type;

   // Controller to datapath
   typedef struct packed {
      logic start;
      logic scan;
      logic commit;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic hit;
      logic miss;
   } dp_status_type;

endpackage

### rtl/scd_datapath.sv
// Datapath: connection table, lookup scan, entry update and result word.
module scd_datapath #(
   parameter int TABLE_ENTRIES = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  scd_pkg::dp_cmd_type              cmd,
   output scd_pkg::dp_status_type           status,
   input  logic [scd_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  logic                             csr_valid,
   input  logic [scd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [scd_pkg::CSR_DATA_W-1:0]   csr_data,
   output logic [scd_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import scd_pkg::*;

   localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam int PAD_W = RSP_TDATA_W - ID_W - 3;

   entry_type entry_mem [TABLE_ENTRIES];

   logic [COUNT_W-1:0] thresh_ff;
   logic [STATE_W-1:0] watch_ff;
   logic [ID_W-1:0]    in_id_ff;
   logic [STATE_W-1:0] in_state_ff;
   logic [CW-1:0]      rd_addr_ff, rd_addr_in;
   logic               pend_ff, pend_in;
   logic [AW-1:0]      rd_idx_ff;
   entry_type          rd_data_ff;
   logic [CW-1:0]      used_ff;
   logic               out_req_ff, out_new_ff, out_full_ff;
   logic [ID_W-1:0]    out_id_ff;

   logic               hit, miss, rd_en, room, same, fire, wr_en;
   logic [COUNT_W-1:0] cnt_inc, new_count;
   logic [AW-1:0]      wr_idx;
   entry_type          wr_data;

   // Compare the word read last cycle; the scan ends when all used entries are seen
   assign hit  = pend_ff && (rd_data_ff.id == in_id_ff);
   assign miss = !pend_ff && (rd_addr_ff == used_ff);
   assign status.hit  = hit;
   assign status.miss = miss;

   // Issue one read per scan cycle until a match stops the walk or all used entries are read
   assign rd_en = cmd.scan && !hit && (rd_addr_ff < used_ff);

   always_comb begin
      rd_addr_in = rd_addr_ff;
      pend_in    = pend_ff;
      if (cmd.start) begin
         rd_addr_in = '0;
         pend_in    = 1'b0;
      end else if (cmd.scan && !hit) begin
         pend_in = rd_en;
         if (rd_en) begin
            rd_addr_in = rd_addr_ff + CW'(1);
         end
      end
   end

   // Work out the updated entry
   assign same      = (rd_data_ff.state == in_state_ff);
   assign cnt_inc   = (rd_data_ff.count == COUNT_MAX) ? rd_data_ff.count
                                                      : rd_data_ff.count + COUNT_W'(1);
   assign new_count = same ? cnt_inc : '0;
   assign fire      = hit && same && !rd_data_ff.marked && (cnt_inc >= thresh_ff)
                      && (in_state_ff == watch_ff);
   assign room      = (used_ff < CW'(TABLE_ENTRIES));
   assign wr_en     = cmd.commit && (hit || room);
   assign wr_idx    = hit ? rd_idx_ff : used_ff[AW-1:0];

   always_comb begin
      wr_data.id    = in_id_ff;
      wr_data.state = in_state_ff;
      if (hit) begin
         wr_data.count  = new_count;
         wr_data.marked = rd_data_ff.marked | fire;
      end else begin
         wr_data.count  = '0;
         wr_data.marked = 1'b0;
      end
   end

   // Table memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_idx] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entry_mem[rd_addr_ff[AW-1:0]];
         rd_idx_ff  <= rd_addr_ff[AW-1:0];
      end
   end

   // Control state: scan position, fill count, configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_addr_ff <= '0;
         pend_ff    <= 1'b0;
         used_ff    <= '0;
         thresh_ff  <= THRESH_RESET;
         watch_ff   <= WATCH_RESET;
      end else begin
         rd_addr_ff <= rd_addr_in;
         pend_ff    <= pend_in;
         if (cmd.commit && !hit && room) begin
            used_ff <= used_ff + CW'(1);
         end
         if (csr_valid) begin
            unique case (csr_index)
               CSR_DWELL_THRESHOLD: thresh_ff <= csr_data;
               CSR_WATCH_STATE:     watch_ff  <= csr_data[STATE_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // Capture the input word and load the result word
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         in_id_ff    <= req_tdata[ID_W-1:0];
         in_state_ff <= req_tdata[ID_W+STATE_W-1:ID_W];
      end
      if (cmd.commit) begin
         out_req_ff  <= fire;
         out_id_ff   <= fire ? in_id_ff : '0;
         out_new_ff  <= !hit;
         out_full_ff <= !hit && !room;
      end
   end

   assign rsp_tdata = {{PAD_W{1'b0}}, out_full_ff, out_new_ff, out_id_ff, out_req_ff};

endmodule

### rtl/scd_controller.sv
// Controller: sequences accept, table scan, commit and result handoff.
module scd_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  scd_pkg::dp_status_type  status,
   output scd_pkg::dp_cmd_type     cmd
);
   import scd_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           slot_free;

   // Result slot frees when empty or taken this cycle
   assign slot_free = !rsp_valid_ff || rsp_tready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_tvalid) state_in = ST_SCAN;
         ST_SCAN:   if (status.hit || status.miss) state_in = ST_COMMIT;
         ST_COMMIT: if (slot_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.start  = req_tvalid;
         end
         ST_SCAN:   cmd.scan   = 1'b1;
         ST_COMMIT: cmd.commit = slot_free;
         default: ;
      endcase
   end

   // Hold the result word until taken
   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

### rtl/stale_connection_detector_core.sv
// Sequence: accept, then a scan of the used entries that stops at the first match, then a commit
// that waits until the result slot is free.
// Time per word grows with entries_used, largest at TABLE_ENTRIES, and is set by the walk over
// the table's single read port, one stored identifier per cycle; a new word waits for the commit.
// A new word is taken while the previous result still waits in the output register.
// Reset (synchronous, active high) empties the table through its fill count, no clearing pass,
// and restores dwell_threshold to 1200 and watch_state to 8.
module stale_connection_detector_core #(
   parameter int TABLE_ENTRIES = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   // req_tdata: conn_id[31:0], conn_state[35:32], zero [39:36]
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [scd_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // rsp_tdata: clean_request[0], clean_id[32:1], was_new[33], table_full[34], zero [39:35]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [scd_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [scd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [scd_pkg::CSR_DATA_W-1:0]   csr_data
);
   import scd_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // Register writes complete at once
   assign csr_ready = 1'b1;

   scd_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   scd_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_tdata (rsp_tdata)
   );

endmodule

### rtl/scd_checker.sv
// Port-level checks of the stale connection detector, bound to the top level.
module scd_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [scd_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import scd_pkg::*;

   // A refused insert is always a new identifier
   a_full_is_new: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[ID_W+2] |-> rsp_tdata[ID_W+1])
      else $error("table_full without was_new");

   // A clean request only comes from a tracked entry
   a_req_not_new: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> !rsp_tdata[ID_W+1])
      else $error("clean_request on a new identifier");

   // The clean identifier is zero unless a request is made
   a_id_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[ID_W:1] == '0)
      else $error("clean_id nonzero without clean_request");

   // A stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

endmodule

bind stale_connection_detector_core scd_checker u_scd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
